// ----- rtl/int8vda_pkg.sv -----
// ----------------------------------------------------------------------------
// int8vda_pkg
// Shared widths and types for the int8 vector distance accumulator: per-lane
// terms, merged group sums and the pipeline control word.
// ----------------------------------------------------------------------------
`default_nettype none

package int8vda_pkg;

   // field widths
   localparam int ElemW      = 8;
   localparam int WordLanes  = 8;
   localparam int CountFldW  = 4;
   localparam int MetricW    = 29;
   localparam int EnergyW    = 27;
   localparam int ElemCountW = 17;

   // per-lane term widths
   localparam int LaneMainW  = 17;
   localparam int LaneSqW    = 15;

   // merged group widths (eight lanes at most)
   localparam int GroupMainW = 21;
   localparam int GroupSqW   = 18;

   // metric codes
   localparam logic MetricEuclid = 1'b0;
   localparam logic MetricDot    = 1'b1;

   // terms one lane produces for one beat
   typedef struct packed {
      logic signed [LaneMainW-1:0] main_term;
      logic [LaneSqW-1:0]          a_sq;
      logic [LaneSqW-1:0]          b_sq;
   } lane_term_type;

   // sums over all lanes of one beat
   typedef struct packed {
      logic signed [GroupMainW-1:0] main_sum;
      logic [GroupSqW-1:0]          a_sum;
      logic [GroupSqW-1:0]          b_sum;
   } group_sum_type;

   // control word travelling alongside the data
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [CountFldW-1:0] count;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/int8vda_lane.sv -----
// ----------------------------------------------------------------------------
// int8vda_lane
// One element lane: forms the main term (squared difference or product) and
// the two squares of one element pair, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module int8vda_lane (
   input  wire logic                                 clock,
   input  wire logic                                 enable,
   input  wire logic                                 lane_active,
   input  wire logic                                 metric_select,
   input  wire logic [int8vda_pkg::ElemW-1:0]        a_elem,
   input  wire logic [int8vda_pkg::ElemW-1:0]        b_elem,
   output      int8vda_pkg::lane_term_type           term
);

   logic signed [int8vda_pkg::ElemW-1:0]   x;
   logic signed [int8vda_pkg::ElemW-1:0]   y;
   logic signed [int8vda_pkg::ElemW:0]     diff;
   logic signed [int8vda_pkg::ElemW:0]     op_a;
   logic signed [int8vda_pkg::ElemW:0]     op_b;
   logic signed [2*int8vda_pkg::ElemW+1:0] prod;
   logic signed [2*int8vda_pkg::ElemW-1:0] x_sq;
   logic signed [2*int8vda_pkg::ElemW-1:0] y_sq;
   int8vda_pkg::lane_term_type             term_in;
   int8vda_pkg::lane_term_type             term_ff;

   // one shared multiplier for the main term
   always_comb begin
      x    = signed'(a_elem);
      y    = signed'(b_elem);
      diff = {x[int8vda_pkg::ElemW-1], x} - {y[int8vda_pkg::ElemW-1], y};
      if (metric_select == int8vda_pkg::MetricDot) begin
         op_a = {x[int8vda_pkg::ElemW-1], x};
         op_b = {y[int8vda_pkg::ElemW-1], y};
      end else begin
         op_a = diff;
         op_b = diff;
      end
      prod = op_a * op_b;
      x_sq = x * x;
      y_sq = y * y;
   end

   // inactive lanes contribute nothing
   always_comb begin
      if (lane_active) begin
         term_in.main_term = prod[int8vda_pkg::LaneMainW-1:0];
         term_in.a_sq      = x_sq[int8vda_pkg::LaneSqW-1:0];
         term_in.b_sq      = y_sq[int8vda_pkg::LaneSqW-1:0];
      end else begin
         term_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

// ----- rtl/int8vda_merge.sv -----
// ----------------------------------------------------------------------------
// int8vda_merge
// Merge stage: adds the terms of all lanes into one set of group sums and
// carries the control word one stage on.
// ----------------------------------------------------------------------------
`default_nettype none

module int8vda_merge #(
   parameter int NUM_LANES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire int8vda_pkg::stage_ctl_type    ctl_in,
   input  wire int8vda_pkg::lane_term_type    terms [NUM_LANES],
   output      int8vda_pkg::stage_ctl_type    ctl_out,
   output      int8vda_pkg::group_sum_type    sums
);

   int8vda_pkg::group_sum_type sums_in;
   int8vda_pkg::group_sum_type sums_ff;
   int8vda_pkg::stage_ctl_type ctl_ff;

   // lane adder chain on narrow values
   always_comb begin
      sums_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         sums_in.main_sum = sums_in.main_sum +
            {{(int8vda_pkg::GroupMainW-int8vda_pkg::LaneMainW)
              {terms[i].main_term[int8vda_pkg::LaneMainW-1]}}, terms[i].main_term};
         sums_in.a_sum = sums_in.a_sum +
            {{(int8vda_pkg::GroupSqW-int8vda_pkg::LaneSqW){1'b0}}, terms[i].a_sq};
         sums_in.b_sum = sums_in.b_sum +
            {{(int8vda_pkg::GroupSqW-int8vda_pkg::LaneSqW){1'b0}}, terms[i].b_sq};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         sums_ff <= sums_in;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   assign sums    = sums_ff;
   assign ctl_out = ctl_ff;

endmodule

`default_nettype wire

// ----- rtl/int8vda_accum.sv -----
// ----------------------------------------------------------------------------
// int8vda_accum
// Running sums, element count and length check; loads the result register on
// the last group and clears the running state.
// ----------------------------------------------------------------------------
`default_nettype none

module int8vda_accum #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        enable,
   input  wire int8vda_pkg::stage_ctl_type                  ctl,
   input  wire int8vda_pkg::group_sum_type                  sums,
   input  wire logic                                        rsp_ready,
   output      logic                                        rsp_valid,
   output      logic signed [int8vda_pkg::MetricW-1:0]      rsp_metric_sum,
   output      logic [int8vda_pkg::EnergyW-1:0]             rsp_a_energy,
   output      logic [int8vda_pkg::EnergyW-1:0]             rsp_b_energy,
   output      logic                                        rsp_length_error
);

   localparam int CntW = int8vda_pkg::ElemCountW;
   localparam logic [CntW-1:0] DimLimit = CntW'(MAX_DIM);
   localparam logic [CntW-1:0] CountMax = '1;

   logic signed [int8vda_pkg::MetricW-1:0] main_ff, main_in;
   logic [int8vda_pkg::EnergyW-1:0]        a_acc_ff, a_acc_in;
   logic [int8vda_pkg::EnergyW-1:0]        b_acc_ff, b_acc_in;
   logic [CntW-1:0]                        count_ff, count_in;
   logic                                   ovf_ff, ovf_in;
   logic [CntW:0]                          count_sum;
   logic                                   take;

   logic signed [int8vda_pkg::MetricW-1:0] out_main_ff;
   logic [int8vda_pkg::EnergyW-1:0]        out_a_ff;
   logic [int8vda_pkg::EnergyW-1:0]        out_b_ff;
   logic                                   out_err_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;

   assign take = enable && ctl.valid;

   // next running sums, wrapping at the output widths
   always_comb begin
      main_in  = main_ff + {{(int8vda_pkg::MetricW-int8vda_pkg::GroupMainW)
                            {sums.main_sum[int8vda_pkg::GroupMainW-1]}}, sums.main_sum};
      a_acc_in = a_acc_ff +
                 {{(int8vda_pkg::EnergyW-int8vda_pkg::GroupSqW){1'b0}}, sums.a_sum};
      b_acc_in = b_acc_ff +
                 {{(int8vda_pkg::EnergyW-int8vda_pkg::GroupSqW){1'b0}}, sums.b_sum};
      count_sum = {1'b0, count_ff} + {{(CntW+1-int8vda_pkg::CountFldW){1'b0}}, ctl.count};
      if (count_sum[CntW]) begin
         count_in = CountMax;
      end else begin
         count_in = count_sum[CntW-1:0];
      end
      ovf_in = ovf_ff || (count_in > DimLimit);
   end

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff  <= '0;
         a_acc_ff <= '0;
         b_acc_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (take) begin
         if (ctl.last) begin
            main_ff  <= '0;
            a_acc_ff <= '0;
            b_acc_ff <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            main_ff  <= main_in;
            a_acc_ff <= a_acc_in;
            b_acc_ff <= b_acc_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   // result beat valid
   always_comb begin
      if (take && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && ctl.last) begin
         out_main_ff <= main_in;
         out_a_ff    <= a_acc_in;
         out_b_ff    <= b_acc_in;
         out_err_ff  <= ovf_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_metric_sum   = out_main_ff;
   assign rsp_a_energy     = out_a_ff;
   assign rsp_b_energy     = out_b_ff;
   assign rsp_length_error = out_err_ff;

endmodule

`default_nettype wire

// ----- rtl/int8_vector_distance_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// int8_vector_distance_accumulator_unit
// Streams two signed int8 vectors in groups of up to eight element pairs and
// returns the squared distance or dot product together with both squared norms.
// ----------------------------------------------------------------------------
// The unit takes one group beat per clock. Each group beat passes through three
// registered stages: the lane multipliers, the lane merge adder and the
// accumulators with the result register; a result beat appears once the last
// group beat has passed all three. The pipeline moves as a whole and holds only
// while a result waits with rsp_ready low; otherwise a group beat is taken in
// every cycle. Lane counts above min(LANES, 8) are clipped to that value. Once
// more than MAX_DIM elements have arrived, length_error is set; the sums may wrap
// at their widths. csr_metric_select chooses squared distance (0) or dot product
// (1); the user writes it only while the unit is idle; the unit does not enforce it.
`default_nettype none

module int8_vector_distance_accumulator_unit #(
   parameter int MAX_DIM = 4096,
   parameter int LANES   = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output      logic                                        req_ready,
   input  wire logic [63:0]                                 req_a_lanes,
   input  wire logic [63:0]                                 req_b_lanes,
   input  wire logic [int8vda_pkg::CountFldW-1:0]           req_lane_count,
   input  wire logic                                        req_last_group,
   output      logic                                        rsp_valid,
   input  wire logic                                        rsp_ready,
   output      logic signed [int8vda_pkg::MetricW-1:0]      rsp_metric_sum,
   output      logic [int8vda_pkg::EnergyW-1:0]             rsp_a_energy,
   output      logic [int8vda_pkg::EnergyW-1:0]             rsp_b_energy,
   output      logic                                        rsp_length_error,
   input  wire logic                                        csr_valid,
   output      logic                                        csr_ready,
   input  wire logic                                        csr_metric_select
);

   localparam int NumLanes = (LANES < int8vda_pkg::WordLanes) ? LANES
                                                              : int8vda_pkg::WordLanes;
   localparam logic [int8vda_pkg::CountFldW-1:0] LaneLimit =
      int8vda_pkg::CountFldW'(NumLanes);

   logic                                   metric_ff;
   logic                                   enable;
   logic [int8vda_pkg::CountFldW-1:0]      clipped_count;
   int8vda_pkg::stage_ctl_type             s1_ctl_ff, s1_ctl_in;
   int8vda_pkg::stage_ctl_type             s2_ctl;
   int8vda_pkg::lane_term_type             lane_terms [NumLanes];
   int8vda_pkg::group_sum_type             group_sums;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= int8vda_pkg::MetricEuclid;
      end else if (csr_valid) begin
         metric_ff <= csr_metric_select;
      end
   end

   // pipeline advances unless a result beat is stuck
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // clip the lane count to the lanes present
   always_comb begin
      if (req_lane_count > LaneLimit) begin
         clipped_count = LaneLimit;
      end else begin
         clipped_count = req_lane_count;
      end
      s1_ctl_in.valid = req_valid;
      s1_ctl_in.last  = req_last_group;
      s1_ctl_in.count = clipped_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (enable) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // element lanes
   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      int8vda_lane u_lane (
         .clock         (clock),
         .enable        (enable),
         .lane_active   (int8vda_pkg::CountFldW'(i) < clipped_count),
         .metric_select (metric_ff),
         .a_elem        (req_a_lanes[int8vda_pkg::ElemW*i +: int8vda_pkg::ElemW]),
         .b_elem        (req_b_lanes[int8vda_pkg::ElemW*i +: int8vda_pkg::ElemW]),
         .term          (lane_terms[i])
      );
   end

   // lane merge
   int8vda_merge #(
      .NUM_LANES (NumLanes)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .ctl_in  (s1_ctl_ff),
      .terms   (lane_terms),
      .ctl_out (s2_ctl),
      .sums    (group_sums)
   );

   // accumulators and result register
   int8vda_accum #(
      .MAX_DIM (MAX_DIM)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .enable           (enable),
      .ctl              (s2_ctl),
      .sums             (group_sums),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_metric_sum   (rsp_metric_sum),
      .rsp_a_energy     (rsp_a_energy),
      .rsp_b_energy     (rsp_b_energy),
      .rsp_length_error (rsp_length_error)
   );

endmodule

`default_nettype wire

// ----- bench/tb_int8_vector_distance_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_int8_vector_distance_accumulator_unit
// Self-checking bench for the int8 vector distance accumulator. A short table
// of hand-picked group beats runs first, then random vector pairs of mixed
// length, mode switches between and inside vectors, and long vectors that
// reach and just pass the element limit. Every result beat is checked field
// by field against a software copy of the accumulators or a typed row's own
// hand-picked result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_int8_vector_distance_accumulator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxDim    = 4096;
   localparam int LaneLimit = 8;
   localparam int CountSat  = 17'h1FFFF;

   // one result beat as the block reports it
   typedef struct packed {
      logic signed [int8vda_pkg::MetricW-1:0] metric;
      logic [int8vda_pkg::EnergyW-1:0]        a_energy;
      logic [int8vda_pkg::EnergyW-1:0]        b_energy;
      logic                                   len_err;
   } distance_result_type;

   // one line of the directed table
   typedef struct packed {
      bit                  set_cfg;
      logic                cfg_value;
      logic [63:0]         a;
      logic [63:0]         b;
      logic [3:0]          cnt;
      logic                last;
      bit                  typed;
      distance_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_a_lanes = '0;
   logic [63:0] req_b_lanes = '0;
   logic [int8vda_pkg::CountFldW-1:0] req_lane_count = '0;
   logic        req_last_group = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [int8vda_pkg::MetricW-1:0] rsp_metric_sum;
   logic [int8vda_pkg::EnergyW-1:0] rsp_a_energy;
   logic [int8vda_pkg::EnergyW-1:0] rsp_b_energy;
   logic        rsp_length_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_metric_select = 1'b0;

   // accumulator copy used for prediction
   logic [31:0] sum_main;
   logic [27:0] sum_a_sq;
   logic [27:0] sum_b_sq;
   logic [16:0] elem_seen;
   logic        too_long;
   logic        mode_metric;

   distance_result_type pending_results[$];
   stim_row_type        directed_rows[$];
   int                  fail_count = 0;
   bit                  burst_mode = 1'b0;
   int unsigned         rsp_hold = 0;

   int8_vector_distance_accumulator_unit #(
      .MAX_DIM(MaxDim),
      .LANES  (LaneLimit)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_a_lanes      (req_a_lanes),
      .req_b_lanes      (req_b_lanes),
      .req_lane_count   (req_lane_count),
      .req_last_group   (req_last_group),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_metric_sum   (rsp_metric_sum),
      .rsp_a_energy     (rsp_a_energy),
      .rsp_b_energy     (rsp_b_energy),
      .rsp_length_error (rsp_length_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_metric_select(csr_metric_select)
   );

   // clock
   always #10 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void clear_sums();
      sum_main  = '0;
      sum_a_sq  = '0;
      sum_b_sq  = '0;
      elem_seen = '0;
      too_long  = 1'b0;
   endfunction

   // fold one group beat into the sums; yields a result on the last group
   function automatic bit accumulate_group(input logic [63:0] a, input logic [63:0] b,
                                           input logic [3:0] cnt, input logic last,
                                           output distance_result_type res);
      int n;
      int lane;
      int x;
      int y;
      int d;
      int total;
      n = (cnt > LaneLimit) ? LaneLimit : int'(cnt);
      for (lane = 0; lane < n; lane++) begin
         x = int'($signed(a[8*lane +: 8]));
         y = int'($signed(b[8*lane +: 8]));
         d = x - y;
         sum_main = sum_main + ((mode_metric == int8vda_pkg::MetricDot) ? x * y : d * d);
         sum_a_sq = 28'(sum_a_sq + x * x);
         sum_b_sq = 28'(sum_b_sq + y * y);
      end
      total = int'(elem_seen) + n;
      elem_seen = (total > CountSat) ? CountSat[16:0] : total[16:0];
      if (elem_seen > MaxDim) too_long = 1'b1;
      res = '0;
      if (!last) return 1'b0;
      res.metric   = sum_main[int8vda_pkg::MetricW-1:0];
      res.a_energy = sum_a_sq[int8vda_pkg::EnergyW-1:0];
      res.b_energy = sum_b_sq[int8vda_pkg::EnergyW-1:0];
      res.len_err  = too_long;
      clear_sums();
      return 1'b1;
   endfunction

   // one group beat on the request channel, then the gap before the next
   task automatic send_group(input logic [63:0] a, input logic [63:0] b, input logic [3:0] cnt,
                             input logic last, input bit typed,
                             input distance_result_type want);
      distance_result_type res;
      int gap;
      req_valid      <= 1'b1;
      req_a_lanes    <= a;
      req_b_lanes    <= b;
      req_lane_count <= cnt;
      req_last_group <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (accumulate_group(a, b, cnt, last, res))
         pending_results.push_back(typed ? want : res);
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop the stream and let the pipeline run dry
   task automatic pause_stream();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_metric(input logic value);
      pause_stream();
      csr_valid         <= 1'b1;
      csr_metric_select <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      mode_metric = value;
   endtask

   function automatic logic [63:0] random_lanes();
      logic [63:0] w;
      int k;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         1: begin
            for (k = 0; k < 8; k++) begin
               case ($urandom_range(0, 3))
                  0: w[8*k +: 8] = 8'h7F;
                  1: w[8*k +: 8] = 8'h80;
                  2: w[8*k +: 8] = 8'h00;
                  default: w[8*k +: 8] = 8'hFF;
               endcase
            end
         end
         2: begin
            for (k = 0; k < 8; k++) w[8*k +: 8] = 8'($urandom_range(0, 8) - 4);
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] random_count();
      int r;
      r = $urandom_range(0, 15);
      if (r < 10) return 4'd8;
      if (r < 14) return 4'($urandom_range(1, 7));
      if (r == 14) return 4'd0;
      return 4'($urandom_range(9, 15));
   endfunction

   function automatic void add_row(input bit set_cfg, input logic cfg_value,
                                   input logic [63:0] a, input logic [63:0] b,
                                   input logic [3:0] cnt, input logic last, input bit typed,
                                   input logic signed [int8vda_pkg::MetricW-1:0] metric,
                                   input logic [int8vda_pkg::EnergyW-1:0] a_e,
                                   input logic [int8vda_pkg::EnergyW-1:0] b_e,
                                   input logic err);
      stim_row_type row;
      row.set_cfg   = set_cfg;
      row.cfg_value = cfg_value;
      row.a         = a;
      row.b         = b;
      row.cnt       = cnt;
      row.last      = last;
      row.typed     = typed;
      row.want      = '{metric, a_e, b_e, err};
      directed_rows.push_back(row);
   endfunction

   // result side: random stall after each accepted beat
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) rsp_hold = burst_mode ? 0 : $urandom_range(0, 3);
      else if (rsp_hold > 0) rsp_hold--;
      rsp_ready <= (rsp_hold == 0);
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_results
      distance_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", longint'(rsp_metric_sum), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_metric_sum !== want.metric)
               report_mismatch("metric_sum", longint'(rsp_metric_sum), longint'(want.metric));
            if (rsp_a_energy !== want.a_energy)
               report_mismatch("a_energy", longint'(rsp_a_energy), longint'(want.a_energy));
            if (rsp_b_energy !== want.b_energy)
               report_mismatch("b_energy", longint'(rsp_b_energy), longint'(want.b_energy));
            if (rsp_length_error !== want.len_err)
               report_mismatch("length_error", longint'(rsp_length_error),
                               longint'(want.len_err));
         end
      end
   end

   initial begin
      int idx;
      int groups;
      int g;
      int random_items;
      stim_row_type row;

      mode_metric = int8vda_pkg::MetricEuclid;
      clear_sums();

      // directed table: typed results for empty, extreme and zero cases, others predicted
      add_row(0, 0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 4'd0, 1, 1, 0, 0, 0, 0);
      add_row(0, 0, {8{8'h7F}}, {8{8'h80}}, 4'd8, 1, 1, 520200, 129032, 131072, 0);
      add_row(0, 0, {8{8'h7F}}, {8{8'h80}}, 4'd15, 1, 1, 520200, 129032, 131072, 0);
      add_row(0, 0, 64'h0123456789ABCDEF, 64'h7F807F807F807F80, 4'd0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'h00000000000000F6, 64'h000000000000000A, 4'd1, 1, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'h8899AABBCCDDEEFF, 64'h7766554433221100, 4'd9, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'h0102030405060708, 64'hFEFDFCFBFAF9F8F7, 4'd4, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'hDEADBEEF01234567, 64'h89ABCDEF7F807F80, 4'd8, 1, 0, 0, 0, 0, 0);
      add_row(1, int8vda_pkg::MetricDot, {8{8'h7F}}, {8{8'h80}}, 4'd8, 1, 1,
              -130048, 129032, 131072, 0);
      add_row(0, 0, {8{8'h80}}, {8{8'h80}}, 4'd8, 1, 1, 131072, 131072, 131072, 0);
      add_row(0, 0, {8{8'hFF}}, {8{8'h01}}, 4'd8, 1, 1, -8, 8, 8, 0);
      add_row(0, 0, {8{8'h7F}}, {8{8'h7F}}, 4'd8, 0, 0, 0, 0, 0, 0);
      // metric flips in the middle of a vector
      add_row(1, int8vda_pkg::MetricEuclid, {8{8'h7F}}, {8{8'h80}}, 4'd8, 1, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd0, 1, 1, 0, 0, 0, 0);
      add_row(0, 0, 64'h55AA55AA55AA55AA, 64'hAA55AA55AA55AA55, 4'd3, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'h1122334455667788, 64'h8877665544332211, 4'd0, 1, 0, 0, 0, 0, 0);
      add_row(0, 0, 64'h0, 64'h0, 4'd8, 1, 1, 0, 0, 0, 0);
      add_row(0, 0, 64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00, 4'd10, 1, 0, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < directed_rows.size(); idx++) begin
         row = directed_rows[idx];
         if (row.set_cfg) write_metric(row.cfg_value);
         send_group(row.a, row.b, row.cnt, row.last, row.typed, row.want);
      end

      // random vector pairs, mostly short, some with a mode switch inside
      random_items = 0;
      while (random_items < 200) begin
         if ($urandom_range(0, 11) == 0) write_metric(1'($urandom_range(0, 1)));
         burst_mode = ($urandom_range(0, 4) == 0);
         groups = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         for (g = 0; g < groups; g++) begin
            if (g > 0 && $urandom_range(0, 14) == 0) write_metric(1'($urandom_range(0, 1)));
            send_group(random_lanes(), random_lanes(), random_count(), g == groups - 1, 0, '0);
            random_items++;
         end
      end

      // exactly the element limit, then just past it
      burst_mode = 1'b0;
      write_metric(int8vda_pkg::MetricEuclid);
      for (g = 0; g < MaxDim / 8; g++)
         send_group(random_lanes(), random_lanes(), 4'd8, g == MaxDim / 8 - 1, 0, '0);
      write_metric(int8vda_pkg::MetricDot);
      for (g = 0; g < MaxDim / 8 + 8; g++)
         send_group(random_lanes(), random_lanes(), 4'd8, g == MaxDim / 8 + 7, 0, '0);

      // a short vector afterwards must start from clean sums
      burst_mode = 1'b0;
      send_group(random_lanes(), random_lanes(), 4'd8, 1, 0, '0);

      pause_stream();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/int8vda_pkg.sv
rtl/int8vda_lane.sv
rtl/int8vda_merge.sv
rtl/int8vda_accum.sv
rtl/int8_vector_distance_accumulator_unit.sv
bench/tb_int8_vector_distance_accumulator_unit.sv
